[src/char_lcd_bus_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_defines.svh
// Assertion macros for the display bus sequencer. They compile to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CLBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clbs check failed");
// next-cycle implication
`define CLBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clbs check failed");
`else
`define CLBS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CLBS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/clbs_pkg.sv]
// ----------------------------------------------------------------------------
// clbs_pkg
// Types, codes and constant tables shared by the display bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS     = 1'd1;
  localparam logic [4:0] ROWS_RESET = 5'd2;
  localparam logic [4:0] ROWS_MAX   = 5'd20;

  // request codes
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_CMD   = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_POS   = 3'd3;
  localparam logic [2:0] ACT_BLINK = 3'd4;

  // pause classes
  localparam logic [1:0] PAUSE_NONE  = 2'd0;
  localparam logic [1:0] PAUSE_SHORT = 2'd1;
  localparam logic [1:0] PAUSE_MID   = 2'd2;
  localparam logic [1:0] PAUSE_LONG  = 2'd3;

  // init sequence bookkeeping
  localparam logic [2:0] INIT_LAST_STEP = 3'd4;
  localparam logic [2:0] RAW_LAST_4BIT  = 3'd3;
  localparam logic [2:0] RAW_LAST_8BIT  = 3'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [4:0] column;
    logic [1:0] row;
    logic       blink_on;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic [1:0] pause_after;
    logic       last;
  } xfer_t;

  typedef enum logic [1:0] {
    SRC_RAW  = 2'd0,
    SRC_INIT = 2'd1,
    SRC_REQ  = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    PART_FULL = 2'd0,
    PART_HI   = 2'd1,
    PART_LO   = 2'd2
  } part_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_RAW    = 5'b00100,
    S_INIT   = 5'b01000,
    S_SINGLE = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       set_mode;
    logic       set_blink;
    logic       emit;
    src_t       src;
    part_t      part;
    logic [2:0] step;
    logic       last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       rows_ok;
    logic       rows_multi;
    logic       four_bit;
    logic       nibble_mode;
    logic       out_free;
  } status_t;

  // DDRAM row base addresses
  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    unique case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  // byte table after the handshake: two-line function set, display on,
  // entry mode, cursor shift, clear
  function automatic logic [7:0] init_byte(input logic [2:0] step, input logic four_bit);
    logic [7:0] val;
    unique case (step)
      3'd0:    val = (four_bit ? 8'h20 : 8'h30) | 8'h08;
      3'd1:    val = 8'h0C;
      3'd2:    val = 8'h06;
      3'd3:    val = 8'h14;
      default: val = 8'h01;
    endcase
    return val;
  endfunction

  function automatic logic [1:0] init_pause(input logic [2:0] step);
    logic [1:0] p;
    unique case (step)
      3'd0:    p = PAUSE_LONG;
      3'd1,
      3'd2,
      3'd3:    p = PAUSE_SHORT;
      default: p = PAUSE_MID;
    endcase
    return p;
  endfunction

endpackage

[src/char_lcd_bus_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Converts display requests into strobed transfers for a character display.
//
// Usage:
//   Configuration (cfg_we/cfg_index/cfg_data) sets bus width and row count;
//   write it only while the block is idle.
//   Input beats (in_valid/in_stall/in_data) carry one request each. The
//   block stalls input while it works on a request and accepts the next one
//   in the cycle after the final transfer is loaded into the output register.
//   Output beats (out_valid/out_stall/out_data) are single bus transfers;
//   last marks the final transfer of a request.
// Timing:
//   A decode state follows acceptance, then one transfer per cycle from the
//   sequencer while the output is not stalled; a request produces 0 to 14
//   transfers, the first of them loaded into the output register after decode.
//   A stall on the output holds the output register and freezes the
//   sequencer until the beat is taken.
// Reset: 8-bit bus, two rows, 8-bit transfers, blink off, output empty.
// ----------------------------------------------------------------------------
`include "char_lcd_bus_sequencer_defines.svh"

module char_lcd_bus_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [clbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  clbs_pkg::req_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output clbs_pkg::xfer_t                  out_data
);

  clbs_pkg::cmd_t    cmd;
  clbs_pkg::status_t status;

  clbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  clbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted request always makes the block busy next cycle
  `CLBS_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
  // nothing is generated while idle
  `CLBS_ASSERT_IMP(a_idle_quiet, clk, rst, !in_stall, !cmd.emit)
  // a high nibble that goes out is followed by its low nibble
  `CLBS_ASSERT_NXT(a_lo_follows_hi, clk, rst, cmd.emit && status.out_free && cmd.part == clbs_pkg::PART_HI, cmd.emit && cmd.part == clbs_pkg::PART_LO)
  // 8-bit mode never splits a byte
  `CLBS_ASSERT_IMP(a_full_in_8bit, clk, rst, cmd.emit && !status.nibble_mode, cmd.part == clbs_pkg::PART_FULL)

endmodule

[src/clbs_ctrl.sv]
// ----------------------------------------------------------------------------
// clbs_ctrl
// Sequencer state machine: walks the handshake, the init byte table or a
// single request byte, splitting bytes into nibbles in 4-bit mode.
// ----------------------------------------------------------------------------
module clbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  clbs_pkg::status_t status,
  output clbs_pkg::cmd_t    cmd
);

  clbs_pkg::state_t state, state_next;
  logic [2:0] step, step_next;
  logic       half, half_next;
  logic       go;
  logic       final_part;
  logic [2:0] raw_last;

  assign in_stall   = (state != clbs_pkg::S_IDLE);
  assign go         = status.out_free;
  assign final_part = !status.nibble_mode || half;
  assign raw_last   = status.four_bit ? clbs_pkg::RAW_LAST_4BIT : clbs_pkg::RAW_LAST_8BIT;

  // next state and commands
  always_comb begin
    state_next    = state;
    step_next     = step;
    half_next     = half;
    cmd.load      = 1'b0;
    cmd.set_mode  = 1'b0;
    cmd.set_blink = 1'b0;
    cmd.emit      = 1'b0;
    cmd.src       = clbs_pkg::SRC_REQ;
    cmd.part      = clbs_pkg::PART_FULL;
    cmd.step      = step;
    cmd.last      = 1'b0;
    unique case (state)
      clbs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = clbs_pkg::S_DECODE;
        end
      end
      clbs_pkg::S_DECODE: begin
        step_next = 3'd0;
        half_next = 1'b0;
        unique case (status.action)
          clbs_pkg::ACT_INIT: begin
            if (status.rows_ok) begin
              cmd.set_mode = 1'b1;
              state_next   = clbs_pkg::S_RAW;
            end else begin
              state_next = clbs_pkg::S_IDLE;
            end
          end
          clbs_pkg::ACT_CMD,
          clbs_pkg::ACT_DATA,
          clbs_pkg::ACT_POS: state_next = clbs_pkg::S_SINGLE;
          clbs_pkg::ACT_BLINK: begin
            cmd.set_blink = 1'b1;
            state_next    = clbs_pkg::S_SINGLE;
          end
          default: state_next = clbs_pkg::S_IDLE;
        endcase
      end
      clbs_pkg::S_RAW: begin
        // handshake transfers, always single beats
        cmd.emit = 1'b1;
        cmd.src  = clbs_pkg::SRC_RAW;
        if (go) begin
          if (step == raw_last) begin
            state_next = clbs_pkg::S_INIT;
            step_next  = status.rows_multi ? 3'd0 : 3'd1;
            half_next  = 1'b0;
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      clbs_pkg::S_INIT: begin
        cmd.emit = 1'b1;
        cmd.src  = clbs_pkg::SRC_INIT;
        cmd.part = !status.nibble_mode ? clbs_pkg::PART_FULL :
                   (half ? clbs_pkg::PART_LO : clbs_pkg::PART_HI);
        cmd.last = final_part && (step == clbs_pkg::INIT_LAST_STEP);
        if (go) begin
          if (!final_part) begin
            half_next = 1'b1;
          end else begin
            half_next = 1'b0;
            if (step == clbs_pkg::INIT_LAST_STEP) begin
              state_next = clbs_pkg::S_IDLE;
            end else begin
              step_next = step + 3'd1;
            end
          end
        end
      end
      clbs_pkg::S_SINGLE: begin
        cmd.emit = 1'b1;
        cmd.src  = clbs_pkg::SRC_REQ;
        cmd.part = !status.nibble_mode ? clbs_pkg::PART_FULL :
                   (half ? clbs_pkg::PART_LO : clbs_pkg::PART_HI);
        cmd.last = final_part;
        if (go) begin
          if (!final_part) begin
            half_next = 1'b1;
          end else begin
            half_next  = 1'b0;
            state_next = clbs_pkg::S_IDLE;
          end
        end
      end
      default: state_next = clbs_pkg::S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clbs_pkg::S_IDLE;
      step  <= 3'd0;
      half  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      half  <= half_next;
    end
  end

endmodule

[src/clbs_dp.sv]
// ----------------------------------------------------------------------------
// clbs_dp
// Datapath: configuration and mode registers, request latch, transfer
// value selection and the output register.
// ----------------------------------------------------------------------------
module clbs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [clbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  clbs_pkg::req_t                      in_data,
  input  clbs_pkg::cmd_t                      cmd,
  output clbs_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output clbs_pkg::xfer_t                     out_data
);

  logic           four_bit;
  logic [4:0]     display_rows;
  logic           nibble_mode;
  logic           blink_enabled;
  clbs_pkg::req_t req;
  logic [7:0]     byte_sel;
  logic [1:0]     pause_sel;
  logic           rs_sel;
  logic [7:0]     position;
  clbs_pkg::xfer_t xfer;
  logic           out_free;

  assign out_free = !out_valid || !out_stall;

  assign status.action      = req.action;
  assign status.rows_ok     = (display_rows <= clbs_pkg::ROWS_MAX);
  assign status.rows_multi  = (display_rows > 5'd1);
  assign status.four_bit    = four_bit;
  assign status.nibble_mode = nibble_mode;
  assign status.out_free    = out_free;

  // configuration and mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit      <= 1'b0;
      display_rows  <= clbs_pkg::ROWS_RESET;
      nibble_mode   <= 1'b0;
      blink_enabled <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          clbs_pkg::CFG_FOUR_BIT: four_bit     <= cfg_data[0];
          default:                display_rows <= cfg_data;
        endcase
      end
      if (cmd.set_mode) begin
        nibble_mode <= four_bit;
      end
      if (cmd.set_blink) begin
        blink_enabled <= req.blink_on;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
  end

  assign position = {3'd0, req.column} + (8'h80 | clbs_pkg::row_offset(req.row));

  // byte source select
  always_comb begin
    byte_sel  = 8'h00;
    pause_sel = clbs_pkg::PAUSE_NONE;
    rs_sel    = 1'b0;
    unique case (cmd.src)
      clbs_pkg::SRC_RAW: begin
        byte_sel  = !four_bit ? 8'h30 :
                    ((cmd.step == clbs_pkg::RAW_LAST_4BIT) ? 8'h02 : 8'h03);
        pause_sel = clbs_pkg::PAUSE_LONG;
      end
      clbs_pkg::SRC_INIT: begin
        byte_sel  = clbs_pkg::init_byte(cmd.step, four_bit);
        pause_sel = clbs_pkg::init_pause(cmd.step);
      end
      default: begin
        unique case (req.action)
          clbs_pkg::ACT_CMD:   byte_sel = req.byte_value;
          clbs_pkg::ACT_DATA: begin
            byte_sel = req.byte_value;
            rs_sel   = 1'b1;
          end
          clbs_pkg::ACT_POS:   byte_sel = position;
          clbs_pkg::ACT_BLINK: byte_sel = 8'h08 | {7'd0, blink_enabled};
          default:             byte_sel = 8'h00;
        endcase
      end
    endcase
  end

  // nibble split; pause goes with the final beat of a byte
  always_comb begin
    xfer.reg_select = rs_sel;
    xfer.last       = cmd.last;
    unique case (cmd.part)
      clbs_pkg::PART_HI: begin
        xfer.bus_value   = {4'd0, byte_sel[7:4]};
        xfer.pause_after = clbs_pkg::PAUSE_NONE;
      end
      clbs_pkg::PART_LO: begin
        xfer.bus_value   = {4'd0, byte_sel[3:0]};
        xfer.pause_after = pause_sel;
      end
      default: begin
        xfer.bus_value   = byte_sel;
        xfer.pause_after = pause_sel;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_data <= xfer;
    end
  end

endmodule
